/* hw/rtl/rpp_pkg.sv */
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants for the point-about-pivot rotation pipeline.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam int COORD_BITS   = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int FRAC_BITS    = 30;

    // Offset from the pivot is exact, one bit wider than a coordinate.
    localparam int DIFF_BITS = COORD_BITS + 1;
    // CORDIC vector in Q2.30 with a guard bit; angle accumulator in 2^32 per turn.
    localparam int CW = 33;
    localparam int ZW = 32;

    localparam logic signed [CW-1:0] CORDIC_START = CW'(32'h26DD3B6A);
    localparam logic signed [CW-1:0] UNIT_Q30     = CW'(1) <<< FRAC_BITS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] pivot_x;
        logic signed [COORD_BITS-1:0] pivot_y;
        logic signed [ANGLE_BITS-1:0] turn_angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_x;
        logic signed [COORD_BITS-1:0] rotated_y;
    } t_out_beat;

    typedef struct packed {
        logic                 vld;
        logic [1:0]           quad;
        logic                 is_zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cvec;

endpackage

/* hw/rtl/rpp_cstep.sv */
// ----------------------------------------------------------------------------
// rpp_cstep
// One registered micro-rotation of the rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module rpp_cstep #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpp_pkg::t_cvec i_vec,
    output rpp_pkg::t_cvec o_vec
);
    import rpp_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    t_cvec                n_vec;
    t_cvec                r_vec;

    // Arithmetic shifts round toward minus infinity.
    assign xs = i_vec.x >>> STEP;
    assign ys = i_vec.y >>> STEP;

    always_comb begin
        n_vec = i_vec;
        if (!i_vec.z[ZW-1]) begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - ATAN_TURN[STEP];
        end else begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + ATAN_TURN[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec.vld <= 1'b0;
        end else begin
            r_vec.vld <= n_vec.vld;
        end
        r_vec.quad    <= n_vec.quad;
        r_vec.is_zero <= n_vec.is_zero;
        r_vec.x       <= n_vec.x;
        r_vec.y       <= n_vec.y;
        r_vec.z       <= n_vec.z;
    end

    assign o_vec = r_vec;

endmodule

/* hw/rtl/rpp_cordic.sv */
// ----------------------------------------------------------------------------
// rpp_cordic
// Pipelined sine/cosine: one stage per CORDIC step, then the quadrant fold.
// ----------------------------------------------------------------------------
module rpp_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic [rpp_pkg::ANGLE_BITS-1:0]        i_angle,
    output logic                                  o_vld,
    output logic signed [rpp_pkg::CW-1:0]         o_cos,
    output logic signed [rpp_pkg::CW-1:0]         o_sin,
    output logic signed [rpp_pkg::CW-1:0]         o_nsin
);
    import rpp_pkg::*;

    t_cvec                v_stage [CORDIC_STEPS+1];
    t_cvec                v_last;
    logic [ANGLE_BITS-3:0] rest;
    logic signed [CW-1:0] x_fix;
    logic signed [CW-1:0] y_fix;
    logic signed [CW-1:0] n_cos;
    logic signed [CW-1:0] n_sin;
    logic                 r_vld;
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;
    logic signed [CW-1:0] r_nsin;

    assign rest = i_angle[ANGLE_BITS-3:0];

    always_comb begin
        v_stage[0].vld     = i_vld;
        v_stage[0].quad    = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        v_stage[0].is_zero = (rest == '0);
        v_stage[0].x       = CORDIC_START;
        v_stage[0].y       = '0;
        v_stage[0].z       = ZW'({rest, {(32-ANGLE_BITS){1'b0}}});
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        rpp_cstep #(
            .STEP (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (v_stage[g]),
            .o_vec   (v_stage[g+1])
        );
    end

    assign v_last = v_stage[CORDIC_STEPS];

    // An angle on an exact quarter turn skips the CORDIC result entirely.
    assign x_fix = v_last.is_zero ? UNIT_Q30 : v_last.x;
    assign y_fix = v_last.is_zero ? '0 : v_last.y;

    always_comb begin
        unique case (v_last.quad)
            QUAD_0: begin
                n_cos = x_fix;
                n_sin = y_fix;
            end
            QUAD_1: begin
                n_cos = -y_fix;
                n_sin = x_fix;
            end
            QUAD_2: begin
                n_cos = -x_fix;
                n_sin = -y_fix;
            end
            QUAD_3: begin
                n_cos = y_fix;
                n_sin = -x_fix;
            end
            default: begin
                n_cos = x_fix;
                n_sin = y_fix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= v_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos  <= n_cos;
        r_sin  <= n_sin;
        r_nsin <= -n_sin;
    end

    assign o_vld  = r_vld;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_nsin = r_nsin;

endmodule

/* hw/rtl/rpp_mix.sv */
// ----------------------------------------------------------------------------
// rpp_mix
// Rotates the offset by (cos, sin), rounds, adds the pivot and saturates.
// ----------------------------------------------------------------------------
module rpp_mix (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic signed [rpp_pkg::DIFF_BITS-1:0]   i_dx,
    input  logic signed [rpp_pkg::DIFF_BITS-1:0]   i_dy,
    input  logic signed [rpp_pkg::COORD_BITS-1:0]  i_px,
    input  logic signed [rpp_pkg::COORD_BITS-1:0]  i_py,
    input  logic signed [rpp_pkg::CW-1:0]          i_cos,
    input  logic signed [rpp_pkg::CW-1:0]          i_sin,
    input  logic signed [rpp_pkg::CW-1:0]          i_nsin,
    output logic                                   o_vld,
    output rpp_pkg::t_out_beat                     o_beat
);
    import rpp_pkg::*;

    // Offsets are split into a signed high part and an unsigned low part so
    // that every multiplier stays near 17 by 33 bits.
    localparam int LO  = 16;
    localparam int HW  = DIFF_BITS - LO;
    localparam int PW  = ((HW > LO + 1) ? HW : LO + 1) + CW;
    localparam int SW  = PW + 1;
    localparam int TW  = SW + LO + 1;
    localparam int QW  = TW - FRAC_BITS;
    localparam int RW  = ((QW > COORD_BITS) ? QW : COORD_BITS) + 1;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (FRAC_BITS - 1);

    logic signed [HW-1:0]   dxh;
    logic signed [HW-1:0]   dyh;
    logic signed [LO:0]     dxl;
    logic signed [LO:0]     dyl;

    // Stage 1: partial products.
    logic                   r1_vld;
    logic signed [PW-1:0]   r1_xh_a, r1_xh_b, r1_xl_a, r1_xl_b;
    logic signed [PW-1:0]   r1_yh_a, r1_yh_b, r1_yl_a, r1_yl_b;
    logic signed [COORD_BITS-1:0] r1_px, r1_py;

    // Stage 2: sums of the high and of the low halves.
    logic                   r2_vld;
    logic signed [SW-1:0]   r2_xh, r2_xl, r2_yh, r2_yl;
    logic signed [COORD_BITS-1:0] r2_px, r2_py;

    // Stage 3: recombined and scaled.
    logic signed [TW-1:0]   tot_x;
    logic signed [TW-1:0]   tot_y;
    logic                   r3_vld;
    logic signed [QW-1:0]   r3_qx, r3_qy;
    logic signed [COORD_BITS-1:0] r3_px, r3_py;

    // Stage 4: pivot added and clamped.
    logic signed [RW-1:0]   sum_x;
    logic signed [RW-1:0]   sum_y;
    t_out_beat              n_beat;
    t_out_beat              r_beat;
    logic                   r4_vld;

    assign dxh = i_dx[DIFF_BITS-1:LO];
    assign dyh = i_dy[DIFF_BITS-1:LO];
    assign dxl = {1'b0, i_dx[LO-1:0]};
    assign dyl = {1'b0, i_dy[LO-1:0]};

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [RW-1:0] v);
        logic [RW-COORD_BITS:0] top;
        logic signed [COORD_BITS-1:0] res;
        top = v[RW-1:COORD_BITS-1];
        if ((&top) || !(|top)) begin
            res = v[COORD_BITS-1:0];
        end else if (v[RW-1]) begin
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    assign tot_x = (TW'(r2_xh) <<< LO) + TW'(r2_xl);
    assign tot_y = (TW'(r2_yh) <<< LO) + TW'(r2_yl);
    assign sum_x = RW'(r3_qx) + RW'(r3_px);
    assign sum_y = RW'(r3_qy) + RW'(r3_py);

    always_comb begin
        n_beat.rotated_x = sat(sum_x);
        n_beat.rotated_y = sat(sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // x' = dx*cos - dy*sin, y' = dx*sin + dy*cos
        r1_xh_a <= dxh * i_cos;
        r1_xh_b <= dyh * i_nsin;
        r1_xl_a <= dxl * i_cos;
        r1_xl_b <= dyl * i_nsin;
        r1_yh_a <= dxh * i_sin;
        r1_yh_b <= dyh * i_cos;
        r1_yl_a <= dxl * i_sin;
        r1_yl_b <= dyl * i_cos;
        r1_px   <= i_px;
        r1_py   <= i_py;

        r2_xh   <= r1_xh_a + r1_xh_b;
        r2_xl   <= r1_xl_a + r1_xl_b + RND;
        r2_yh   <= r1_yh_a + r1_yh_b;
        r2_yl   <= r1_yl_a + r1_yl_b + RND;
        r2_px   <= r1_px;
        r2_py   <= r1_py;

        // Dropping the low fraction bits floors; the half added above rounds.
        r3_qx   <= tot_x[TW-1:FRAC_BITS];
        r3_qy   <= tot_y[TW-1:FRAC_BITS];
        r3_px   <= r2_px;
        r3_py   <= r2_py;

        r_beat  <= n_beat;
    end

    assign o_vld  = r4_vld;
    assign o_beat = r_beat;

endmodule

/* hw/rtl/rotate_point_about_pivot_unit.sv */
// ----------------------------------------------------------------------------
// rotate_point_about_pivot_unit
// Rotates a Q16.16 point about a pivot by a binary angle, saturating output.
// ----------------------------------------------------------------------------
// A beat is taken on every cycle that start is high; busy is always low, so a
// new point may be issued each clock. Each result appears on o_result for one
// cycle with o_done high, after its start passes through one input register, 30
// CORDIC stages (one micro-rotation each), the quadrant fold, and four stages
// of multiply, sum, rescale and pivot add with saturation. The receiver cannot
// stall the pipeline, so it must take every result on the cycle it is shown.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rpp_pkg::t_in_beat   i_cmd,
    output logic                o_done,
    output rpp_pkg::t_out_beat  o_result
);
    import rpp_pkg::*;

    localparam int DLY = CORDIC_STEPS + 1;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } t_side;

    logic                  r_vld;
    t_side                 r_side;
    logic [ANGLE_BITS-1:0] r_ang;
    t_side                 n_side;
    t_side                 r_dly [DLY];
    logic                  cs_vld;
    logic signed [CW-1:0]  cs_cos;
    logic signed [CW-1:0]  cs_sin;
    logic signed [CW-1:0]  cs_nsin;

    assign busy = 1'b0;

    always_comb begin
        n_side.dx = DIFF_BITS'(i_cmd.point_x) - DIFF_BITS'(i_cmd.pivot_x);
        n_side.dy = DIFF_BITS'(i_cmd.point_y) - DIFF_BITS'(i_cmd.pivot_y);
        n_side.px = i_cmd.pivot_x;
        n_side.py = i_cmd.pivot_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_ang  <= i_cmd.turn_angle;
    end

    // Offsets and pivot wait here while the CORDIC produces sin and cos.
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_side;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    rpp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_angle (r_ang),
        .o_vld   (cs_vld),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin),
        .o_nsin  (cs_nsin)
    );

    rpp_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cs_vld),
        .i_dx    (r_dly[DLY-1].dx),
        .i_dy    (r_dly[DLY-1].dy),
        .i_px    (r_dly[DLY-1].px),
        .i_py    (r_dly[DLY-1].py),
        .i_cos   (cs_cos),
        .i_sin   (cs_sin),
        .i_nsin  (cs_nsin),
        .o_vld   (o_done),
        .o_beat  (o_result)
    );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the point-about-pivot rotation unit against a bit-exact CORDIC model.
// ----------------------------------------------------------------------------
// A queue of commands is filled up front. It holds a short directed set:
// identity, the exact quarter turns, the extreme angles and saturating
// coordinates. After that come random commands of several magnitudes. The
// driver issues the commands with random idle gaps and with bursts that have
// no gaps. Each accepted beat is run through a local model of the rotation and
// the result is queued. The monitor takes every o_done beat and compares it
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
    import rpp_pkg::*;

    localparam int NUM_RANDOM   = 1300;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [95:0] COORD_HI = (96'sd1 <<< (COORD_BITS - 1)) - 96'sd1;
    localparam logic signed [95:0] COORD_LO = -(96'sd1 <<< (COORD_BITS - 1));

    localparam logic [31:0] ARCTAN_STEP [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_beat   cmd_bus = '0;
    logic       o_done;
    t_out_beat  o_result;

    t_in_beat   pending_cmds [$];
    t_out_beat  expected_points [$];
    int         idle_left   = 0;
    int         burst_left  = 0;
    int         error_count = 0;

    rotate_point_about_pivot_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_bus),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cosine and sine in Q2.30. The part of the angle below a quarter turn goes
    // through the CORDIC, and the quadrant is then applied by swap and negate.
    function automatic void turn_cos_sin(input logic [ANGLE_BITS-1:0] angle,
                                         output longint cos_q30,
                                         output longint sin_q30);
        logic [1:0]            quad;
        logic [ANGLE_BITS-3:0] rest;
        longint                x, y, z, xs, ys, t;
        quad = angle[ANGLE_BITS-1 -: 2];
        rest = angle[ANGLE_BITS-3:0];
        if (rest == '0) begin
            x = longint'(1) <<< 30;
            y = 0;
        end else begin
            x = 64'sh26DD3B6A;
            y = 0;
            z = longint'(rest) <<< (32 - ANGLE_BITS);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ARCTAN_STEP[i]);
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ARCTAN_STEP[i]);
                end
            end
        end
        case (quad)
            QUAD_1: begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_2: begin
                x = -x;
                y = -y;
            end
            QUAD_3: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    // Rescale an exact Q30 sum with rounding half up, add the pivot and clamp.
    function automatic logic [COORD_BITS-1:0] place_coord(input logic signed [95:0] sum,
                                                          input longint pivot);
        logic signed [95:0] v;
        v = ((sum + (96'sd1 <<< 29)) >>> 30) + 96'(pivot);
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_out_beat rotate_about_pivot(input t_in_beat cmd);
        longint             cx, cy, c, s;
        logic signed [95:0] dx, dy;
        t_out_beat          res;
        cx = longint'($signed(cmd.pivot_x));
        cy = longint'($signed(cmd.pivot_y));
        dx = 96'(longint'($signed(cmd.point_x)) - cx);
        dy = 96'(longint'($signed(cmd.point_y)) - cy);
        turn_cos_sin(cmd.turn_angle, c, s);
        res.rotated_x = place_coord(dx * 96'(c) - dy * 96'(s), cx);
        res.rotated_y = place_coord(dx * 96'(s) + dy * 96'(c), cy);
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a gapless burst.
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 82)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord(input int sh);
        return $signed($urandom) >>> sh;
    endfunction

    function automatic logic [COORD_BITS-1:0] edge_coord();
        case ($urandom_range(0, 4))
            0: return COORD_HI[COORD_BITS-1:0];
            1: return COORD_LO[COORD_BITS-1:0];
            2: return COORD_HI[COORD_BITS-1:0] - $urandom_range(0, 1 << 20);
            3: return COORD_LO[COORD_BITS-1:0] + $urandom_range(0, 1 << 20);
            default: return '0;
        endcase
    endfunction

    function automatic t_in_beat random_cmd();
        t_in_beat cmd;
        int       sh;
        cmd.turn_angle = ANGLE_BITS'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: sh = $urandom_range(9, 14);
            4, 5:       sh = 0;
            8, 9:       sh = $urandom_range(3, 6);
            default:    sh = $urandom_range(4, 12);
        endcase
        cmd.point_x = rand_coord(sh);
        cmd.point_y = rand_coord(sh);
        cmd.pivot_x = rand_coord(sh);
        cmd.pivot_y = rand_coord(sh);
        if ($urandom_range(0, 9) == 6) begin
            // Angles on or right next to a quarter turn.
            cmd.turn_angle = {2'($urandom_range(0, 3)), {(ANGLE_BITS - 2){1'b0}}}
                             + ANGLE_BITS'($urandom_range(0, 4)) - ANGLE_BITS'(2);
        end
        if ($urandom_range(0, 9) == 7) begin
            cmd.point_x = edge_coord();
            cmd.point_y = edge_coord();
            cmd.pivot_x = edge_coord();
            cmd.pivot_y = edge_coord();
        end
        return cmd;
    endfunction

    task automatic queue_cmd(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                             input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                             input logic [ANGLE_BITS-1:0] angle);
        t_in_beat cmd;
        cmd.point_x    = px;
        cmd.point_y    = py;
        cmd.pivot_x    = cx;
        cmd.pivot_y    = cy;
        cmd.turn_angle = angle;
        pending_cmds.push_back(cmd);
    endtask

    task automatic note_mismatch(input string field, input logic [COORD_BITS-1:0] want,
                                 input logic [COORD_BITS-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // Driver: a beat counts at the edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_points.push_back(rotate_about_pivot(cmd_bus));
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd_bus   <= pending_cmds.pop_front();
                    start     <= 1'b1;
                    idle_left = next_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every o_done beat is checked.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_done) begin
            if (expected_points.size() == 0) begin
                note_mismatch("unexpected beat", '0, o_result.rotated_x);
            end else begin
                want = expected_points.pop_front();
                if (o_result.rotated_x !== want.rotated_x)
                    note_mismatch("rotated_x", want.rotated_x, o_result.rotated_x);
                if (o_result.rotated_y !== want.rotated_y)
                    note_mismatch("rotated_y", want.rotated_y, o_result.rotated_y);
            end
        end
    end

    initial begin
        logic [COORD_BITS-1:0] cmax, cmin;
        cmax = COORD_HI[COORD_BITS-1:0];
        cmin = COORD_LO[COORD_BITS-1:0];

        // Identity, exact quarter turns, the angle extremes, an eighth turn and a zero point.
        queue_cmd(32'h0003_8000, 32'hFFFD_4000, 32'h0001_0000, 32'h0002_0000, 16'h0000);
        queue_cmd(32'h0003_8000, 32'hFFFD_4000, 32'h0001_0000, 32'h0002_0000, 16'h4000);
        queue_cmd(32'h0003_8000, 32'hFFFD_4000, 32'h0001_0000, 32'h0002_0000, 16'h8000);
        queue_cmd(32'h0003_8000, 32'hFFFD_4000, 32'h0001_0000, 32'h0002_0000, 16'hC000);
        queue_cmd(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
        queue_cmd(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h7FFF);
        queue_cmd(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8001);
        queue_cmd(32'h0010_0000, 32'h0007_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        queue_cmd(32'h0010_0000, 32'h0007_0000, 32'hFFF0_0000, 32'h0005_0000, 16'h2000);
        queue_cmd(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h1234);
        // Coordinate extremes and saturation in both directions.
        queue_cmd(cmax, cmax, cmax, cmax, 16'h2AAA);
        queue_cmd(cmin, cmin, cmin, cmin, 16'hD555);
        queue_cmd(cmax, cmax, 32'h0, 32'h0, 16'h2000);
        queue_cmd(cmin, cmin, 32'h0, 32'h0, 16'h2000);
        queue_cmd(cmax, cmin, cmin, cmax, 16'h0000);
        queue_cmd(cmax, cmin, cmin, cmax, 16'h4000);
        queue_cmd(cmin, cmax, cmax, cmin, 16'h8000);
        queue_cmd(cmin, cmax, cmax, cmin, 16'hC000);
        queue_cmd(cmax, 32'h0, cmin, 32'h0, 16'h6000);
        queue_cmd(32'h0, cmin, 32'h0, cmax, 16'hA000);
        queue_cmd(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 16'h3FFF);
        queue_cmd(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);

        for (int n = 0; n < NUM_RANDOM; n++)
            pending_cmds.push_back(random_cmd());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge i_clk);
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_points.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_cstep.sv
hw/rtl/rpp_cordic.sv
hw/rtl/rpp_mix.sv
hw/rtl/rotate_point_about_pivot_unit.sv
tb/testbench.sv
